>>> rtl/c3k_pkg.sv
// Shared types and constants of the 3x3 convolution filter.
package c3k_pkg;

    typedef logic [7:0]  t_pixel;
    typedef logic [9:0]  t_pos;
    typedef logic [2:0]  t_cfg_idx;
    typedef logic [23:0] t_cfg_data;

    localparam int unsigned MAX_HEIGHT = 1024;

    localparam t_cfg_idx CFG_FRAME_WIDTH   = 3'd0;
    localparam t_cfg_idx CFG_FRAME_HEIGHT  = 3'd1;
    localparam t_cfg_idx CFG_KERNEL_TOP    = 3'd2;
    localparam t_cfg_idx CFG_KERNEL_MID    = 3'd3;
    localparam t_cfg_idx CFG_KERNEL_BOTTOM = 3'd4;
    localparam t_cfg_idx CFG_DIVISOR       = 3'd5;

    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd512;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd256;
    localparam logic [23:0] RST_KERNEL_TOP   = 24'hFFFFFF;
    localparam logic [23:0] RST_KERNEL_MID   = 24'hFF08FF;
    localparam logic [23:0] RST_KERNEL_BOT   = 24'hFFFFFF;
    localparam logic [7:0]  RST_DIVISOR      = 8'd1;

endpackage

>>> rtl/c3k_pix_if.sv
// Pixel input channel of the 3x3 convolution filter.
interface c3k_pix_if;
    import c3k_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

>>> rtl/c3k_res_if.sv
// Result output channel of the 3x3 convolution filter.
interface c3k_res_if;
    import c3k_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel filtered;
    t_pos   out_row;
    t_pos   out_col;

    modport source (output valid, output filtered, output out_row, output out_col,
                    input ready);
    modport sink   (input valid, input filtered, input out_row, input out_col,
                    output ready);
endinterface

>>> rtl/conv3x3_kernel_filter.sv
// Top level of the 3x3 convolution filter over a raster pixel stream.
//
// Pixels enter on i_pix in raster order, one transaction per pixel. Each
// interior pixel (not in the first or last row or column of the frame)
// yields one transaction on o_res: the kernel-weighted sum of the 3x3
// neighborhood, divided by the divisor (truncated), clamped to 0..255,
// with the row and column of the window centre. Border pixels yield nothing.
// The two previous rows sit in one line memory, read at accept and written
// back the next cycle. One shared multiplier walks the nine taps, then a
// radix-2 divider produces eight quotient bits.
// A border pixel returns to idle after the update step; an interior one runs
// the nine-step MAC, a check step, the eight-step divider (skipped if the sum
// saturates or is negative) and the output step; only idle accepts pixels.
// The result sits in an output register, so a stalled receiver holds only
// the next result, not the next accept; a second result waits in the last
// state until the register frees.
// Reset clears state, counters, window and the valid flag and loads the
// default configuration; the line memory holds no data until each column is
// written by the first two rows. Configuration is for the user to write
// via i_cfg_we/i_cfg_idx/i_cfg_data only while idle; the block has no guard.
module conv3x3_kernel_filter #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    c3k_pix_if.sink          i_pix,
    c3k_res_if.source        o_res,
    input  logic             i_cfg_we,
    input  c3k_pkg::t_cfg_idx  i_cfg_idx,
    input  c3k_pkg::t_cfg_data i_cfg_data
);
    import c3k_pkg::*;

    localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
    localparam int CX = (AW > 10) ? AW : 10;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [10:0] r_fw;
    logic [10:0] r_fh;
    logic [23:0] r_kt;
    logic [23:0] r_km;
    logic [23:0] r_kb;
    logic [7:0]  r_div;

    logic [2:0]    r_state;
    logic [AW-1:0] r_col_cnt;
    logic [9:0]    r_row_cnt;
    logic [AW-1:0] r_cur_col;
    logic [9:0]    r_cur_row;
    t_pixel        r_px;
    t_pixel        r_win [9];
    logic [3:0]    r_idx;
    logic signed [19:0] r_acc;
    logic [7:0]    r_rem;
    logic [7:0]    r_num;
    logic [2:0]    r_bit;

    logic [15:0]   r_mem [MAX_WIDTH];
    logic [15:0]   r_rd;

    logic          r_ov;
    t_pixel        r_filt;
    t_pos          r_orow;
    t_pos          r_ocol;

    logic [WW-1:0] w;
    logic [10:0]   h;
    logic [WW-1:0] fw_x;
    logic          in_acc;
    logic          col_wrap;
    logic [10:0]   row_tmp;
    logic [AW-1:0] c_cur;
    logic [9:0]    row_cur;
    logic [WW-1:0] c_inc;
    logic [10:0]   r_inc;
    logic [AW-1:0] n_col_cnt;
    logic [9:0]    n_row_cnt;
    logic [71:0]   kern;
    logic signed [7:0]  coef;
    logic signed [16:0] prod;
    logic [7:0]    dd;
    logic [19:0]   lim;
    logic [8:0]    rem_sh;
    logic          out_load;
    logic [CX-1:0] ocol_x;
    logic [CX-1:0] cur_col_x;

    assign fw_x = WW'(r_fw);

    always_comb begin
        if (fw_x < WW'(3)) begin
            w = WW'(3);
        end else if (fw_x > WW'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = fw_x;
        end
        if (r_fh < 11'd3) begin
            h = 11'd3;
        end else if (r_fh > 11'(MAX_HEIGHT)) begin
            h = 11'(MAX_HEIGHT);
        end else begin
            h = r_fh;
        end
    end

    assign in_acc = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == S_IDLE);

    always_comb begin
        col_wrap = (WW'(r_col_cnt) >= w);
        row_tmp  = col_wrap ? (11'(r_row_cnt) + 11'd1) : 11'(r_row_cnt);
        c_cur    = col_wrap ? '0 : r_col_cnt;
        row_cur  = (row_tmp >= h) ? 10'd0 : row_tmp[9:0];
        c_inc    = WW'(c_cur) + WW'(1);
        r_inc    = 11'(row_cur) + 11'd1;
        if (c_inc >= w) begin
            n_col_cnt = '0;
            n_row_cnt = (r_inc >= h) ? 10'd0 : r_inc[9:0];
        end else begin
            n_col_cnt = c_inc[AW-1:0];
            n_row_cnt = row_cur;
        end
    end

    assign kern   = {r_kb, r_km, r_kt};
    assign coef   = signed'(kern[r_idx*8 +: 8]);
    assign prod   = coef * signed'({1'b0, r_win[r_idx]});
    assign dd     = (r_div == 8'd0) ? 8'd1 : r_div;
    assign lim    = 20'({dd, 8'd0});
    assign rem_sh = {r_rem, r_num[7]};
    assign out_load  = (r_state == S_OUT) && (!r_ov || o_res.ready);
    assign cur_col_x = CX'(r_cur_col);
    assign ocol_x    = cur_col_x - CX'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= RST_FRAME_WIDTH;
            r_fh  <= RST_FRAME_HEIGHT;
            r_kt  <= RST_KERNEL_TOP;
            r_km  <= RST_KERNEL_MID;
            r_kb  <= RST_KERNEL_BOT;
            r_div <= RST_DIVISOR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:   r_fw  <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT:  r_fh  <= i_cfg_data[10:0];
                CFG_KERNEL_TOP:    r_kt  <= i_cfg_data;
                CFG_KERNEL_MID:    r_km  <= i_cfg_data;
                CFG_KERNEL_BOTTOM: r_kb  <= i_cfg_data;
                CFG_DIVISOR:       r_div <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd <= r_mem[c_cur];
        end
        if (r_state == S_UPD) begin
            r_mem[r_cur_col] <= {r_rd[7:0], r_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px      <= i_pix.pixel;
            r_cur_col <= c_cur;
            r_cur_row <= row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_idx     <= '0;
            r_bit     <= '0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_col_cnt <= n_col_cnt;
                        r_row_cnt <= n_row_cnt;
                        r_state   <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= r_rd[15:8];
                    r_win[3] <= r_win[4];
                    r_win[4] <= r_win[5];
                    r_win[5] <= r_rd[7:0];
                    r_win[6] <= r_win[7];
                    r_win[7] <= r_win[8];
                    r_win[8] <= r_px;
                    r_idx    <= '0;
                    if (r_cur_row >= 10'd2 && r_cur_col >= AW'(2)) begin
                        r_state <= S_MAC;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MAC: begin
                    r_idx <= r_idx + 4'd1;
                    if (r_idx == 4'd8) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_bit <= '0;
                    if (r_acc[19] || (unsigned'(r_acc) >= lim)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_UPD: r_acc <= '0;
            S_MAC: r_acc <= r_acc + 20'(prod);
            S_CHK: begin
                if (r_acc[19]) begin
                    r_num <= 8'd0;
                end else if (unsigned'(r_acc) >= lim) begin
                    r_num <= 8'd255;
                end else begin
                    r_rem <= r_acc[15:8];
                    r_num <= r_acc[7:0];
                end
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, dd}) begin
                    r_rem <= 8'(rem_sh - {1'b0, dd});
                    r_num <= {r_num[6:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[7:0];
                    r_num <= {r_num[6:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_filt <= r_num;
            r_orow <= r_cur_row - 10'd1;
            r_ocol <= ocol_x[9:0];
        end
    end

    assign o_res.valid    = r_ov;
    assign o_res.filtered = r_filt;
    assign o_res.out_row  = r_orow;
    assign o_res.out_col  = r_ocol;

`ifndef SYNTHESIS
    a_acc_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_UPD))
        else $error("accepted pixel did not reach the update step");

    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_OUT))
        else $error("result register loaded outside the output step");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < dd))
        else $error("divider remainder not below divisor");

    a_no_emit_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_cur_row >= 10'd2 && r_cur_col >= AW'(2)))
        else $error("border pixel entered the weighted sum");
`endif

endmodule
